// ----- rtl/core/tsq_pkg.sv -----
// Shared types, constants and helpers for the turntable photo sequencer.
`timescale 1ns / 1ps

package tsq_pkg;

  // Width of the motor step counter
  localparam int unsigned STEP_W = 16;
  localparam int unsigned SAT_W  = (STEP_W > 16) ? STEP_W : 16;
  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

  localparam int unsigned PROG_W  = 7;
  localparam int unsigned SPM_W   = 16;
  localparam int unsigned DELAY_W = 14;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DELAY_W-1:0] WAIT_MAX = {DELAY_W{1'b1}};
  localparam logic [PULSE_W-1:0] SHUT_MAX = {PULSE_W{1'b1}};
  localparam logic [PROG_W-1:0]  PROG_MAX = {PROG_W{1'b1}};

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PHOTO_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_MOVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHOTO_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTTER_EN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTTER_PULSE  = 3'd4;

  // Register reset values
  localparam logic [PROG_W-1:0]  RST_PHOTO_COUNT   = 7'd24;
  localparam logic [SPM_W-1:0]   RST_STEPS_PER_MOVE = 16'd1600;
  localparam logic [DELAY_W-1:0] RST_PHOTO_DELAY   = 14'd2000;
  localparam logic               RST_SHUTTER_EN    = 1'b1;
  localparam logic [PULSE_W-1:0] RST_SHUTTER_PULSE = 16'd100;

  typedef struct packed {
    logic step_due;
    logic hold;
    logic restart;
  } tick_t;

  typedef struct packed {
    logic              shutter_level;
    logic              step_pulse;
    logic              motor_enable;
    logic [PROG_W-1:0] photos_done;
    logic              run_complete;
  } res_t;

  typedef struct packed {
    logic [PROG_W-1:0]  photo_count;
    logic [SPM_W-1:0]   steps_per_move;
    logic [DELAY_W-1:0] photo_delay_ms;
    logic               shutter_enable;
    logic [PULSE_W-1:0] shutter_pulse_ms;
  } cfg_t;

  // Clamp the programmed step count to what the step counter can hold
  function automatic logic [STEP_W-1:0] sat_steps(input logic [SPM_W-1:0] s);
    logic [SAT_W-1:0] wide;
    wide = SAT_W'(s);
    if (wide > SAT_W'(STEP_MAX)) begin
      return STEP_MAX;
    end
    return wide[STEP_W-1:0];
  endfunction

endpackage

// ----- rtl/core/tsq_ifs.sv -----
// Handshake channel interfaces for the turntable photo sequencer.
`timescale 1ns / 1ps

interface tsq_in_if;
  logic valid;
  logic ready;
  logic step_due;
  logic hold;
  logic restart;
  modport source(output valid, output step_due, output hold, output restart, input ready);
  modport sink(input valid, input step_due, input hold, input restart, output ready);
endinterface

interface tsq_out_if;
  logic                      valid;
  logic                      ready;
  logic                      shutter_level;
  logic                      step_pulse;
  logic                      motor_enable;
  logic [tsq_pkg::PROG_W-1:0] photos_done;
  logic                      run_complete;
  modport source(output valid, output shutter_level, output step_pulse,
                 output motor_enable, output photos_done, output run_complete,
                 input ready);
  modport sink(input valid, input shutter_level, input step_pulse,
               input motor_enable, input photos_done, input run_complete,
               output ready);
endinterface

interface tsq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tsq_pkg::CFG_IDX_W-1:0]  index;
  logic [tsq_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/tsq_seq.sv -----
// Run state and per-tick update of the photo sequencer.
`timescale 1ns / 1ps

module tsq_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tick_en,
  input  tsq_pkg::tick_t  tick,
  input  tsq_pkg::cfg_t   cfg,
  output tsq_pkg::res_t   res
);

  typedef struct packed {
    logic                        open;
    logic [tsq_pkg::PULSE_W-1:0] timer;
  } shut_t;

  logic [tsq_pkg::PROG_W-1:0]  progress_r, progress_nxt;
  logic                        moving_r, moving_nxt;
  logic [tsq_pkg::STEP_W-1:0]  steps_left_r, steps_left_nxt;
  logic [tsq_pkg::DELAY_W-1:0] wait_timer_r, wait_timer_nxt;
  logic                        shutter_open_r, shutter_open_nxt;
  logic [tsq_pkg::PULSE_W-1:0] shutter_timer_r, shutter_timer_nxt;
  logic                        run_started_r, run_started_nxt;
  logic                        pulse;

  // Open on fire, close once the pulse has lasted long enough
  function automatic shut_t shutter_svc(input logic en, input logic fire, input shut_t s,
                                        input logic [tsq_pkg::PULSE_W-1:0] len);
    shut_t o;
    o = s;
    if (en) begin
      if (fire && !o.open) begin
        o.open  = 1'b1;
        o.timer = '0;
      end
      if (o.open && o.timer >= len) begin
        o.open = 1'b0;
      end
    end
    return o;
  endfunction

  always_comb begin
    shut_t sh;
    logic  start_hold;
    progress_nxt   = progress_r;
    moving_nxt     = moving_r;
    steps_left_nxt = steps_left_r;
    wait_timer_nxt = wait_timer_r;
    sh.open        = shutter_open_r;
    sh.timer       = shutter_timer_r;
    run_started_nxt = run_started_r;
    pulse          = 1'b0;
    start_hold     = 1'b0;

    if (tick.restart) begin
      progress_nxt    = '0;
      moving_nxt      = 1'b0;
      steps_left_nxt  = '0;
      wait_timer_nxt  = tsq_pkg::WAIT_MAX;
      sh.open         = 1'b0;
      sh.timer        = '0;
      run_started_nxt = 1'b0;
    end

    if (wait_timer_nxt != tsq_pkg::WAIT_MAX) begin
      wait_timer_nxt = wait_timer_nxt + 1'b1;
    end
    if (sh.timer != tsq_pkg::SHUT_MAX) begin
      sh.timer = sh.timer + 1'b1;
    end

    // First tick of a run: enable motor and fire the shutter
    if (progress_nxt == '0 && !moving_nxt && !run_started_nxt) begin
      run_started_nxt = 1'b1;
      sh.timer        = '0;
      sh = shutter_svc(cfg.shutter_enable, 1'b1, sh, cfg.shutter_pulse_ms);
    end

    if (progress_nxt < cfg.photo_count && !moving_nxt) begin
      // Motion waits for the opening pulse of the run to end
      start_hold = (progress_nxt == '0) && (sh.timer < cfg.shutter_pulse_ms);
      if (!start_hold && wait_timer_nxt >= cfg.photo_delay_ms) begin
        steps_left_nxt = tsq_pkg::sat_steps(cfg.steps_per_move);
        moving_nxt     = 1'b1;
      end
      sh = shutter_svc(cfg.shutter_enable, 1'b0, sh, cfg.shutter_pulse_ms);
    end

    if (moving_nxt && !tick.hold && tick.step_due && steps_left_nxt != '0) begin
      steps_left_nxt = steps_left_nxt - 1'b1;
      pulse          = 1'b1;
    end

    if (moving_nxt && steps_left_nxt == '0) begin
      moving_nxt = 1'b0;
      if (progress_nxt != tsq_pkg::PROG_MAX) begin
        progress_nxt = progress_nxt + 1'b1;
      end
      wait_timer_nxt = '0;
      if (progress_nxt < cfg.photo_count) begin
        sh = shutter_svc(cfg.shutter_enable, 1'b1, sh, cfg.shutter_pulse_ms);
      end
    end

    shutter_open_nxt  = sh.open;
    shutter_timer_nxt = sh.timer;

    res.shutter_level = shutter_open_nxt;
    res.step_pulse    = pulse;
    res.motor_enable  = run_started_nxt;
    res.photos_done   = progress_nxt;
    res.run_complete  = (progress_nxt >= cfg.photo_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      progress_r      <= '0;
      moving_r        <= 1'b0;
      steps_left_r    <= '0;
      wait_timer_r    <= tsq_pkg::WAIT_MAX;
      shutter_open_r  <= 1'b0;
      shutter_timer_r <= '0;
      run_started_r   <= 1'b0;
    end else if (tick_en) begin
      progress_r      <= progress_nxt;
      moving_r        <= moving_nxt;
      steps_left_r    <= steps_left_nxt;
      wait_timer_r    <= wait_timer_nxt;
      shutter_open_r  <= shutter_open_nxt;
      shutter_timer_r <= shutter_timer_nxt;
      run_started_r   <= run_started_nxt;
    end
  end

  // The step counter only holds a count during a move
  a_idle_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    !moving_r |-> steps_left_r == '0)
    else $error("steps left while not moving");

  a_step_gated: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en && res.step_pulse |-> tick.step_due && !tick.hold)
    else $error("step issued without step_due or while held");

  a_run_started: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en |=> run_started_r)
    else $error("run not started after a tick");

  a_restart_progress: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en && tick.restart |=> progress_r <= 7'd1)
    else $error("progress too high after restart");

endmodule

// ----- rtl/core/turntable_photo_sequencer.sv -----
// Top level of the turntable photo sequencer: channels, configuration and result register.
`timescale 1ns / 1ps

// Each accepted input beat is one millisecond tick and yields exactly one result
// beat. A beat is held in an input register, evaluated against the run state and
// moved into the result register; the block sustains one tick per clock cycle,
// and the input stalls only while both registers hold a beat and the result is
// not taken.
// Configuration writes are always taken (cfg ready is tied high) and should land
// only while no tick is in flight.
module turntable_photo_sequencer (
  input  logic          clk,
  input  logic          rst_n,
  tsq_in_if.sink        in_bus,
  tsq_out_if.source     out_bus,
  tsq_cfg_if.sink       cfg_bus
);

  tsq_pkg::cfg_t  cfg_r;
  logic           s1_valid_r;
  tsq_pkg::tick_t s1_tick_r;
  logic           out_valid_r;
  tsq_pkg::res_t  out_res_r;
  tsq_pkg::res_t  res;
  logic           out_free;
  logic           s1_adv;
  logic           in_take;

  assign out_free = !out_valid_r || out_bus.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_bus.ready = !s1_valid_r || out_free;
  assign in_take  = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.photo_count      <= tsq_pkg::RST_PHOTO_COUNT;
      cfg_r.steps_per_move   <= tsq_pkg::RST_STEPS_PER_MOVE;
      cfg_r.photo_delay_ms   <= tsq_pkg::RST_PHOTO_DELAY;
      cfg_r.shutter_enable   <= tsq_pkg::RST_SHUTTER_EN;
      cfg_r.shutter_pulse_ms <= tsq_pkg::RST_SHUTTER_PULSE;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        tsq_pkg::REG_PHOTO_COUNT:    cfg_r.photo_count      <= cfg_bus.data[tsq_pkg::PROG_W-1:0];
        tsq_pkg::REG_STEPS_PER_MOVE: cfg_r.steps_per_move   <= cfg_bus.data[tsq_pkg::SPM_W-1:0];
        tsq_pkg::REG_PHOTO_DELAY:    cfg_r.photo_delay_ms   <= cfg_bus.data[tsq_pkg::DELAY_W-1:0];
        tsq_pkg::REG_SHUTTER_EN:     cfg_r.shutter_enable   <= cfg_bus.data[0];
        tsq_pkg::REG_SHUTTER_PULSE:  cfg_r.shutter_pulse_ms <= cfg_bus.data[tsq_pkg::PULSE_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_tick_r.step_due <= in_bus.step_due;
      s1_tick_r.hold     <= in_bus.hold;
      s1_tick_r.restart  <= in_bus.restart;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  tsq_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (s1_adv),
    .tick    (s1_tick_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_bus.valid         = out_valid_r;
  assign out_bus.shutter_level = out_res_r.shutter_level;
  assign out_bus.step_pulse    = out_res_r.step_pulse;
  assign out_bus.motor_enable  = out_res_r.motor_enable;
  assign out_bus.photos_done   = out_res_r.photos_done;
  assign out_bus.run_complete  = out_res_r.run_complete;

  // Input stalls only behind a held beat that cannot move on
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> s1_valid_r && out_valid_r && !out_bus.ready)
    else $error("input stalled without a blocked beat");

  a_step_needs_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.step_pulse |-> out_res_r.motor_enable)
    else $error("step pulse with motor disabled");

  a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("evaluated beat lost");

endmodule
